/* sv/psd_pkg.sv */
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the charge-integration pulse shape
// discriminator: field widths, register indexes, status codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF   = 14;
   localparam int PSD_FRAC_BITS_DEF = 14;

   // stream field widths
   localparam int SAMPLE_FIELD_W = 14;
   localparam int REQ_DATA_W     = 16;
   localparam int INT_W          = 25;
   localparam int PSD_W          = 16;
   localparam int STATUS_W       = 2;
   localparam int RSP_PAD_W      = 6;
   localparam int RSP_DATA_W     = 2 * INT_W + PSD_W + RSP_PAD_W;

   // configuration port
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 12;
   localparam int LEN_W       = 10;
   localparam int START_W     = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BASELINE_LEN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GATE_START   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SHORT_LEN    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_LEN     = 8'd3;

   // register reset values
   localparam logic [LEN_W-1:0]   BASELINE_LEN_RST = 10'd100;
   localparam logic [START_W-1:0] GATE_START_RST   = 12'd198;
   localparam logic [LEN_W-1:0]   SHORT_LEN_RST    = 10'd40;
   localparam logic [LEN_W-1:0]   LONG_LEN_RST     = 10'd150;

   // sample counter
   localparam int               IDX_W     = 13;
   localparam logic [IDX_W-1:0] INDEX_MAX = 13'd8191;

   // integral saturation limits (magnitudes)
   localparam int INT_POS_MAX = 16777215;
   localparam int INT_NEG_MAG = 16777216;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   // controller states
   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_CHECK,
      ST_MUL_A,
      ST_MUL_B,
      ST_NUM,
      ST_INT_DIV,
      ST_PSD_NUM,
      ST_PSD_DIV,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic sample_accept;
      logic gate_short;
      logic mul_a;
      logic mul_b;
      logic int_start;
      logic int_store;
      logic psd_start;
      logic psd_store;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic too_short;
      logic li_zero;
      logic div_done;
   } stat_type;

endpackage

`default_nettype wire

/* sv/pulse_shape_discriminator.sv */
// The divider is DIV_W = max(SAMPLE_BITS + 20, PSD_FRAC_BITS + 26) bits wide,
// 40 bits at the defaults. Throughput: one sample per cycle within a waveform;
// after the last sample the input is closed while the shared one-bit-per-cycle
// divider runs up to three times, twice when the long integral is zero.
// A too-short waveform skips the arithmetic; CHECK and FINISH keep the input closed.
// Reset: synchronous, active high; registers take their defaults, counters clear.
// ----------------------------------------------------------------------------
// pulse_shape_discriminator
// Charge-integration pulse shape discriminator: baseline, short and long gate
// integrals and the (long - short) / long shape ratio per waveform.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_shape_discriminator #(
   parameter int SAMPLE_BITS   = psd_pkg::SAMPLE_BITS_DEF,
   parameter int PSD_FRAC_BITS = psd_pkg::PSD_FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // sample stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [psd_pkg::REQ_DATA_W-1:0]  req_tdata,  // [13:0] sample
   input  wire logic                            req_tlast,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [psd_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // long_integral, short_integral, psd
   output logic      [psd_pkg::STATUS_W-1:0]    rsp_tuser,  // status
   // configuration writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [psd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [psd_pkg::CSR_DATA_W-1:0]  csr_data
);

   psd_pkg::cmd_type  cmd;
   psd_pkg::stat_type stat;

   // registers take writes in any cycle
   assign csr_ready = 1'b1;

   // controller
   psd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   psd_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .PSD_FRAC_BITS (PSD_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire

/* sv/psd_div.sv */
// ----------------------------------------------------------------------------
// psd_div
// Unsigned restoring divider, one quotient bit per cycle. A start pulse loads
// the operands; done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_div #(
   parameter int DIV_W = 40,
   parameter int DEN_W = 25
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   trial_diff;
   logic             fits;

   // one restoring step: shift in the next dividend bit and try the divisor
   always_comb begin
      trial      = {rem_ff, quo_ff[DIV_W-1]};
      trial_diff = trial - {1'b0, den_ff};
      fits       = trial >= {1'b0, den_ff};
   end

   // next values
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand and partial result registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* sv/psd_ctrl.sv */
// ----------------------------------------------------------------------------
// psd_ctrl
// Controller of the discriminator: accumulates samples until the last one,
// then sequences the two integrals, the shape ratio and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tlast,
   output logic                  req_tready,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   input  wire psd_pkg::stat_type stat,
   output psd_pkg::cmd_type      cmd
);

   psd_pkg::state_type state_ff, state_in;
   logic               pass_ff, pass_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         psd_pkg::ST_ACCUM: begin
            if (req_tvalid && req_tlast) state_in = psd_pkg::ST_CHECK;
         end
         psd_pkg::ST_CHECK: begin
            pass_in  = 1'b0;
            state_in = stat.too_short ? psd_pkg::ST_FINISH : psd_pkg::ST_MUL_A;
         end
         psd_pkg::ST_MUL_A:   state_in = psd_pkg::ST_MUL_B;
         psd_pkg::ST_MUL_B:   state_in = psd_pkg::ST_NUM;
         psd_pkg::ST_NUM:     state_in = psd_pkg::ST_INT_DIV;
         psd_pkg::ST_INT_DIV: begin
            if (stat.div_done) begin
               pass_in  = 1'b1;
               state_in = pass_ff ? psd_pkg::ST_PSD_NUM : psd_pkg::ST_MUL_A;
            end
         end
         psd_pkg::ST_PSD_NUM: begin
            state_in = stat.li_zero ? psd_pkg::ST_FINISH : psd_pkg::ST_PSD_DIV;
         end
         psd_pkg::ST_PSD_DIV: begin
            if (stat.div_done) state_in = psd_pkg::ST_FINISH;
         end
         psd_pkg::ST_FINISH: begin
            if (out_free) state_in = psd_pkg::ST_ACCUM;
         end
         default: state_in = psd_pkg::ST_ACCUM;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      req_tready     = 1'b0;
      cmd.gate_short = pass_ff;
      case (state_ff)
         psd_pkg::ST_ACCUM: begin
            req_tready        = 1'b1;
            cmd.sample_accept = req_tvalid;
         end
         psd_pkg::ST_MUL_A:   cmd.mul_a     = 1'b1;
         psd_pkg::ST_MUL_B:   cmd.mul_b     = 1'b1;
         psd_pkg::ST_NUM:     cmd.int_start = 1'b1;
         psd_pkg::ST_INT_DIV: cmd.int_store = stat.div_done;
         psd_pkg::ST_PSD_NUM: cmd.psd_start = !stat.li_zero;
         psd_pkg::ST_PSD_DIV: cmd.psd_store = stat.div_done;
         psd_pkg::ST_FINISH:  cmd.out_load  = out_free;
         default:             cmd           = '0;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psd_pkg::ST_ACCUM;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   // a new result never overwrites one that is still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a pending result");

   // the last sample closes the input until the result is formed
   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after last sample");

   // divider finishes only while a division is awaited
   a_div_state: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == psd_pkg::ST_INT_DIV ||
                         state_ff == psd_pkg::ST_PSD_DIV))
      else $error("divider done outside a division state");

   // the ratio is never started on a zero long integral
   a_psd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.psd_start |-> !stat.li_zero)
      else $error("ratio started with zero denominator");
`endif

endmodule

`default_nettype wire

/* sv/psd_dp.sv */
// ----------------------------------------------------------------------------
// psd_dp
// Datapath of the discriminator: configuration registers, window flags and
// sample accumulators, a shared multiplier, the shared divider, saturation
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_dp #(
   parameter int SAMPLE_BITS   = psd_pkg::SAMPLE_BITS_DEF,
   parameter int PSD_FRAC_BITS = psd_pkg::PSD_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [psd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              csr_valid,
   input  wire logic [psd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [psd_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire psd_pkg::cmd_type                  cmd,
   output psd_pkg::stat_type                      stat,
   output logic      [psd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic      [psd_pkg::STATUS_W-1:0]      rsp_tuser
);

   localparam int LEN_W     = psd_pkg::LEN_W;
   localparam int START_W   = psd_pkg::START_W;
   localparam int IDX_W     = psd_pkg::IDX_W;
   localparam int INT_W     = psd_pkg::INT_W;
   localparam int PSD_W     = psd_pkg::PSD_W;
   localparam int ACC_W     = SAMPLE_BITS + LEN_W;
   localparam int PROD_W    = ACC_W + LEN_W;
   localparam int DIFF_W    = INT_W + 1;
   localparam int PSD_NUM_W = DIFF_W + PSD_FRAC_BITS;
   localparam int DIV_W     = (PROD_W > PSD_NUM_W) ? PROD_W : PSD_NUM_W;
   localparam int DEN_W     = INT_W;
   localparam int PSD_HI    = ((1 << (PSD_FRAC_BITS + 1)) - 1 < 32767) ?
                              (1 << (PSD_FRAC_BITS + 1)) - 1 : 32767;
   localparam int PSD_LO_MAG = ((1 << (PSD_FRAC_BITS + 1)) < 32768) ?
                               (1 << (PSD_FRAC_BITS + 1)) : 32768;

   // configuration registers
   logic [LEN_W-1:0]   blen_ff;
   logic [START_W-1:0] gstart_ff;
   logic [LEN_W-1:0]   slen_ff;
   logic [LEN_W-1:0]   llen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff   <= psd_pkg::BASELINE_LEN_RST;
         gstart_ff <= psd_pkg::GATE_START_RST;
         slen_ff   <= psd_pkg::SHORT_LEN_RST;
         llen_ff   <= psd_pkg::LONG_LEN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            psd_pkg::REG_BASELINE_LEN: blen_ff   <= csr_data[LEN_W-1:0];
            psd_pkg::REG_GATE_START:   gstart_ff <= csr_data[START_W-1:0];
            psd_pkg::REG_SHORT_LEN:    slen_ff   <= csr_data[LEN_W-1:0];
            psd_pkg::REG_LONG_LEN:     llen_ff   <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // window flags for the current sample
   logic [SAMPLE_BITS-1:0] sample;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W:0]         gate_open;
   logic [IDX_W:0]         short_end;
   logic [IDX_W:0]         long_end;
   logic [LEN_W-1:0]       gate_max;
   logic [IDX_W:0]         need;
   logic [IDX_W:0]         need_gate;
   logic                   in_base, in_short, in_long;

   always_comb begin
      sample    = SAMPLE_BITS'(req_tdata[psd_pkg::SAMPLE_FIELD_W-1:0]);
      gate_open = (IDX_W + 1)'(gstart_ff);
      short_end = gate_open + (IDX_W + 1)'(slen_ff);
      long_end  = gate_open + (IDX_W + 1)'(llen_ff);
      in_base   = idx_ff < IDX_W'(blen_ff);
      in_short  = ((IDX_W + 1)'(idx_ff) >= gate_open) && ((IDX_W + 1)'(idx_ff) < short_end);
      in_long   = ((IDX_W + 1)'(idx_ff) >= gate_open) && ((IDX_W + 1)'(idx_ff) < long_end);
      gate_max  = (slen_ff > llen_ff) ? slen_ff : llen_ff;
      need_gate = gate_open + (IDX_W + 1)'(gate_max);
      need      = ((IDX_W + 1)'(blen_ff) > need_gate) ? (IDX_W + 1)'(blen_ff) : need_gate;
      idx_in    = (idx_ff == psd_pkg::INDEX_MAX) ? idx_ff : idx_ff + 1'b1;
   end

   // sample counter, accumulators and short-waveform flag
   logic [ACC_W-1:0] bacc_ff, sacc_ff, lacc_ff;
   logic             too_short_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         idx_ff  <= '0;
         bacc_ff <= '0;
         sacc_ff <= '0;
         lacc_ff <= '0;
      end else if (cmd.sample_accept) begin
         idx_ff <= idx_in;
         if (in_base)  bacc_ff <= bacc_ff + ACC_W'(sample);
         if (in_short) sacc_ff <= sacc_ff + ACC_W'(sample);
         if (in_long)  lacc_ff <= lacc_ff + ACC_W'(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         too_short_ff <= 1'b0;
      end else if (cmd.sample_accept && req_tlast) begin
         too_short_ff <= (IDX_W + 1)'(idx_in) < need;
      end
   end

   // shared multiplier: gate length times baseline sum, then baseline
   // length times gate sum
   logic [LEN_W-1:0]  gate_len;
   logic [ACC_W-1:0]  gate_sum;
   logic [LEN_W-1:0]  mul_len;
   logic [ACC_W-1:0]  mul_val;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] prod_a_ff, prod_b_ff;

   always_comb begin
      gate_len = cmd.gate_short ? slen_ff : llen_ff;
      gate_sum = cmd.gate_short ? sacc_ff : lacc_ff;
      mul_len  = cmd.mul_a ? gate_len : blen_ff;
      mul_val  = cmd.mul_a ? bacc_ff : gate_sum;
      product  = PROD_W'(mul_len) * PROD_W'(mul_val);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_a) prod_a_ff <= product;
      if (cmd.mul_b) prod_b_ff <= product;
   end

   // integral numerator as sign and magnitude
   logic              a_ge_b;
   logic [PROD_W-1:0] num_mag;

   always_comb begin
      a_ge_b  = prod_a_ff >= prod_b_ff;
      num_mag = a_ge_b ? prod_a_ff - prod_b_ff : prod_b_ff - prod_a_ff;
   end

   // ratio numerator and denominator as sign and magnitude
   logic signed [INT_W-1:0]  li_ff, si_ff;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_mag;
   logic [DEN_W-1:0]         li_mag;
   logic [PSD_NUM_W-1:0]     psd_num;

   always_comb begin
      diff     = DIFF_W'(li_ff) - DIFF_W'(si_ff);
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      li_mag   = li_ff[INT_W-1] ? DEN_W'(-li_ff) : DEN_W'(li_ff);
      psd_num  = {diff_mag, {PSD_FRAC_BITS{1'b0}}};
   end

   // shared divider
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DEN_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;
   logic             neg_ff;

   always_comb begin
      div_start    = cmd.int_start || cmd.psd_start;
      div_dividend = cmd.psd_start ? DIV_W'(psd_num) : DIV_W'(num_mag);
      div_divisor  = cmd.psd_start ? li_mag : DEN_W'(blen_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.int_start)      neg_ff <= !a_ge_b;
      else if (cmd.psd_start) neg_ff <= diff[DIFF_W-1] ^ li_ff[INT_W-1];
   end

   psd_div #(
      .DIV_W (DIV_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // integral: signed quotient saturated to the result range; with no
   // baseline samples the integral is minus the gate sum
   logic [DIV_W-1:0]        int_mag;
   logic                    int_neg;
   logic signed [INT_W-1:0] int_val;

   always_comb begin
      int_mag = (blen_ff == '0) ? DIV_W'(gate_sum) : div_quotient;
      int_neg = (blen_ff == '0) ? 1'b1 : neg_ff;
      if (int_neg) begin
         if (int_mag > DIV_W'(psd_pkg::INT_NEG_MAG)) int_val = INT_W'(-psd_pkg::INT_NEG_MAG);
         else                                        int_val = -INT_W'(int_mag);
      end else begin
         if (int_mag > DIV_W'(psd_pkg::INT_POS_MAX)) int_val = INT_W'(psd_pkg::INT_POS_MAX);
         else                                        int_val = INT_W'(int_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.int_store) begin
         if (cmd.gate_short) si_ff <= int_val;
         else                li_ff <= int_val;
      end
   end

   // shape ratio saturated to the fixed-point range
   logic signed [PSD_W-1:0] psd_val;
   logic signed [PSD_W-1:0] psd_ff;

   always_comb begin
      if (neg_ff) begin
         if (div_quotient > DIV_W'(PSD_LO_MAG)) psd_val = -PSD_W'(PSD_LO_MAG);
         else                                   psd_val = -PSD_W'(div_quotient);
      end else begin
         if (div_quotient > DIV_W'(PSD_HI)) psd_val = PSD_W'(PSD_HI);
         else                               psd_val = PSD_W'(div_quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.psd_store) psd_ff <= psd_val;
   end

   // result register
   logic [INT_W-1:0]             out_li_ff, out_si_ff;
   logic [PSD_W-1:0]             out_psd_ff;
   logic [psd_pkg::STATUS_W-1:0] out_status_ff;
   logic                         li_zero;

   assign li_zero = li_ff == '0;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (too_short_ff) begin
            out_li_ff     <= '0;
            out_si_ff     <= '0;
            out_psd_ff    <= '0;
            out_status_ff <= psd_pkg::STATUS_SHORT;
         end else if (li_zero) begin
            out_li_ff     <= li_ff;
            out_si_ff     <= si_ff;
            out_psd_ff    <= '0;
            out_status_ff <= psd_pkg::STATUS_ZERO;
         end else begin
            out_li_ff     <= li_ff;
            out_si_ff     <= si_ff;
            out_psd_ff    <= psd_ff;
            out_status_ff <= psd_pkg::STATUS_OK;
         end
      end
   end

   assign rsp_tdata = {{psd_pkg::RSP_PAD_W{1'b0}}, out_psd_ff, out_si_ff, out_li_ff};
   assign rsp_tuser = out_status_ff;

   // status to the controller
   assign stat.too_short = too_short_ff;
   assign stat.li_zero   = li_zero;
   assign stat.div_done  = div_done;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pulse shape discriminator. Streams digitizer
// waveforms through the sample port under a range of gate settings, predicts
// the integrals, psd and status of each waveform, and checks every result
// transaction against that prediction in arrival order.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int INT_W         = psd_pkg::INT_W;
   localparam int PSD_W         = psd_pkg::PSD_W;
   localparam int STATUS_W      = psd_pkg::STATUS_W;
   localparam int SETTLE_CYCLES = 150;   // divider latency plus margin
   localparam int STALL_LIMIT   = 5000;  // cycles with no transaction at all
   localparam int HOLD_CYCLES   = 800;   // long result-side hold-off
   localparam int PHASE_ITEMS   = 70;
   localparam int RANDOM_PHASES = 9;
   localparam int MAX_REPORTS   = 10;
   localparam int SAMPLE_MAX    = 16383;
   localparam int PSD_HI        = 32767;
   localparam int PSD_LO        = -32768;

   typedef struct packed {
      logic signed [INT_W-1:0] long_int;
      logic signed [INT_W-1:0] short_int;
      logic signed [PSD_W-1:0] psd;
      logic [STATUS_W-1:0]     status;
   } pulse_result_type;

   typedef enum int {SHAPE_NOISE, SHAPE_FLAT, SHAPE_DIP, SHAPE_BUMP} shape_kind_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [psd_pkg::REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                            req_tlast  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [psd_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]             rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [psd_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [psd_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   logic hold_rsp      = 1'b0;
   int   rsp_idle_pct  = 0;
   int   send_idle_pct = 0;
   int   idle_cycles   = 0;

   // shadow copy of the gate registers
   int shd_baseline_len = psd_pkg::BASELINE_LEN_RST;
   int shd_gate_start   = psd_pkg::GATE_START_RST;
   int shd_short_len    = psd_pkg::SHORT_LEN_RST;
   int shd_long_len     = psd_pkg::LONG_LEN_RST;

   // predicted waveform state
   int     wave_index = 0;
   longint base_sum   = 0;
   longint short_sum  = 0;
   longint long_sum   = 0;

   pulse_result_type expected_pulses[$];
   int               wave_q[$];

   int mismatches   = 0;
   int n_results    = 0;
   int n_samples    = 0;
   int n_waves      = 0;
   int n_settings   = 0;
   int n_psd_sat    = 0;
   int status_seen[4];

   pulse_shape_discriminator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // gate_len * baseline mean - gate sum, formed once and truncated toward zero
   function automatic longint charge_integral(int gate_len, longint gate_sum);
      longint num;
      if (shd_baseline_len == 0) num = -gate_sum;
      else num = (longint'(gate_len) * base_sum - longint'(shd_baseline_len) * gate_sum)
                 / longint'(shd_baseline_len);
      return clamp_range(num, -longint'(psd_pkg::INT_NEG_MAG), longint'(psd_pkg::INT_POS_MAX));
   endfunction

   // accumulate one accepted sample; on the last one queue the waveform result
   task automatic track_sample(input int smp, input bit lst);
      int               need;
      longint           li;
      longint           si;
      longint           ratio;
      pulse_result_type r;
      if (wave_index < shd_baseline_len) base_sum += smp;
      if (wave_index >= shd_gate_start && wave_index < shd_gate_start + shd_short_len)
         short_sum += smp;
      if (wave_index >= shd_gate_start && wave_index < shd_gate_start + shd_long_len)
         long_sum += smp;
      if (wave_index < int'(psd_pkg::INDEX_MAX)) wave_index++;
      if (lst) begin
         need = shd_gate_start + ((shd_short_len > shd_long_len) ? shd_short_len : shd_long_len);
         if (shd_baseline_len > need) need = shd_baseline_len;
         r = '0;
         if (wave_index < need) begin
            r.status = psd_pkg::STATUS_SHORT;
         end else begin
            li = charge_integral(shd_long_len, long_sum);
            si = charge_integral(shd_short_len, short_sum);
            r.long_int  = li[INT_W-1:0];
            r.short_int = si[INT_W-1:0];
            if (li == 0) begin
               r.status = psd_pkg::STATUS_ZERO;
            end else begin
               ratio = ((li - si) * (longint'(1) << psd_pkg::PSD_FRAC_BITS_DEF)) / li;
               if (ratio > PSD_HI || ratio < PSD_LO) n_psd_sat++;
               ratio = clamp_range(ratio, PSD_LO, PSD_HI);
               r.psd    = ratio[PSD_W-1:0];
               r.status = psd_pkg::STATUS_OK;
            end
         end
         expected_pulses.push_back(r);
         wave_index = 0;
         base_sum   = 0;
         short_sum  = 0;
         long_sum   = 0;
      end
   endtask

   // ------------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------------

   always @(posedge clock) begin : check_results
      pulse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         status_seen[rsp_tuser]++;
         if (expected_pulses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result transaction: long %0d short %0d psd %0d status %0d",
                        $signed(rsp_tdata[INT_W-1:0]), $signed(rsp_tdata[2*INT_W-1:INT_W]),
                        $signed(rsp_tdata[2*INT_W+PSD_W-1:2*INT_W]), rsp_tuser);
         end else begin
            want = expected_pulses.pop_front();
            if (rsp_tdata[INT_W-1:0] !== want.long_int ||
                rsp_tdata[2*INT_W-1:INT_W] !== want.short_int ||
                rsp_tdata[2*INT_W+PSD_W-1:2*INT_W] !== want.psd ||
                rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result %0d mismatch: expected long %0d short %0d psd %0d status %0d",
                           n_results, want.long_int, want.short_int, want.psd, want.status);
                  $display("   got long %0d short %0d psd %0d status %0d",
                           $signed(rsp_tdata[INT_W-1:0]), $signed(rsp_tdata[2*INT_W-1:INT_W]),
                           $signed(rsp_tdata[2*INT_W+PSD_W-1:2*INT_W]), rsp_tuser);
               end
            end
         end
      end
   end

   // result-side ready, random or held off
   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, expected_pulses.size());
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic set_idling(input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      rsp_idle_pct <= rcv_pct;
   endtask

   // one sample transaction, with an optional gap in front
   task automatic send_sample(input int smp, input bit lst);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, 14'(smp)};
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_samples++;
      track_sample(smp, lst);
   endtask

   task automatic send_wave();
      for (int i = 0; i < wave_q.size(); i++) send_sample(wave_q[i], i == wave_q.size() - 1);
      n_waves++;
   endtask

   // random noise, a flat level, or a noisy baseline level with a decaying dip or bump from the gate opening
   function automatic int shaped_sample(int i, int level, int amp, shape_kind_type shape);
      int v;
      int d;
      int sh;
      case (shape)
         SHAPE_NOISE: v = $urandom_range(0, SAMPLE_MAX);
         SHAPE_FLAT:  v = level;
         default: begin
            v = level + int'($urandom_range(0, 6)) - 3;
            d = 0;
            if (i >= shd_gate_start) begin
               sh = (i - shd_gate_start) / 2;
               d  = (sh > 30) ? 0 : (amp >> sh);
            end
            v = (shape == SHAPE_DIP) ? v - d : v + d;
         end
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v;
   endfunction

   task automatic build_wave(input int len, input shape_kind_type shape);
      int level;
      int amp;
      level = $urandom_range(0, SAMPLE_MAX);
      amp   = $urandom_range(0, 12000);
      wave_q.delete();
      for (int i = 0; i < len; i++) wave_q.push_back(shaped_sample(i, level, amp, shape));
   endtask

   // mostly complete waveforms, some cut short
   task automatic send_random_wave();
      int need;
      int len;
      need = shd_gate_start + ((shd_short_len > shd_long_len) ? shd_short_len : shd_long_len);
      if (shd_baseline_len > need) need = shd_baseline_len;
      if ($urandom_range(0, 9) == 0) len = (need > 1) ? $urandom_range(1, need - 1) : 1;
      else len = need + $urandom_range(0, 5);
      if (len < 1) len = 1;
      build_wave(len, shape_kind_type'($urandom_range(0, 3)));
      send_wave();
   endtask

   // wait until every result is back and the divider has surely finished
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid is left high so back-to-back writes keep it asserted
   task automatic write_reg(input logic [psd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [psd_pkg::CSR_DATA_W-1:0]  val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         psd_pkg::REG_BASELINE_LEN: shd_baseline_len = val & 12'h3FF;
         psd_pkg::REG_GATE_START:   shd_gate_start   = val;
         psd_pkg::REG_SHORT_LEN:    shd_short_len    = val & 12'h3FF;
         psd_pkg::REG_LONG_LEN:     shd_long_len     = val & 12'h3FF;
         default: ;
      endcase
   endtask

   // all four gate registers plus a write to an unused index; upper bits of
   // the 10-bit registers carry junk that must be dropped
   task automatic configure(input int bl, input int gs, input int sl, input int ll,
                            input logic [psd_pkg::CSR_INDEX_W-1:0] junk_idx);
      settle();
      write_reg(psd_pkg::REG_BASELINE_LEN, {2'($urandom), 10'(bl)});
      write_reg(psd_pkg::REG_GATE_START, 12'(gs));
      write_reg(psd_pkg::REG_SHORT_LEN, {2'($urandom), 10'(sl)});
      write_reg(psd_pkg::REG_LONG_LEN, {2'($urandom), 10'(ll)});
      write_reg(junk_idx, 12'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      n_settings++;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // one full waveform with the gate registers as they come out of reset
   task automatic test_reset_defaults();
      set_idling(8, 57);
      build_wave(360, SHAPE_DIP);
      send_wave();
   endtask

   task automatic test_directed_cases();
      set_idling(8, 57);
      configure(1, 1, 1, 2, 8'hFF);
      // long integral -1 with a large short one: psd saturates high
      wave_q = '{1000, 0, 2001};
      send_wave();
      // long integral +1: psd saturates low
      wave_q = '{1000, 0, 1999};
      send_wave();
      // flat waveform: long integral zero
      wave_q = '{1000, 1000, 1000};
      send_wave();
      // sample extremes
      wave_q = '{0, SAMPLE_MAX, SAMPLE_MAX};
      send_wave();
      wave_q = '{SAMPLE_MAX, 0, 0};
      send_wave();
      // waveforms ending before the long gate closes
      wave_q = '{5, 6};
      send_wave();
      wave_q = '{SAMPLE_MAX};
      send_wave();
      // gates opening inside the baseline window
      configure(4, 1, 1, 2, 8'h04);
      wave_q = '{100, 200, 300, 400};
      send_wave();
      // no baseline, short gate longer than long gate
      configure(0, 0, 2, 1, 8'h80);
      wave_q = '{7, 9};
      send_wave();
   endtask

   task automatic test_random_settings();
      int bl;
      int gs;
      int phase_start;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < 3) set_idling(8, 57);
         else if (p < 6) set_idling(57, 8);
         else set_idling(0, 0);
         bl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
         gs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, bl) : bl + $urandom_range(0, 8);
         configure(bl, gs, $urandom_range(0, 12), $urandom_range(0, 12),
                   8'($urandom_range(4, 255)));
         phase_start = n_samples;
         while (n_samples - phase_start < PHASE_ITEMS) send_random_wave();
      end
   endtask

   // results held back for a long stretch while samples keep coming
   task automatic test_output_backpressure();
      set_idling(0, 8);
      configure(2, 2, 2, 4, 8'($urandom_range(4, 255)));
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         begin
            repeat (10) send_random_wave();
         end
      join
   endtask

   // long baseline and gate windows, so the sums and integrals grow large
   task automatic test_long_waveform();
      set_idling(0, 0);
      configure(600, 20, 300, 600, 8'($urandom_range(4, 255)));
      build_wave(625, SHAPE_DIP);
      send_wave();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_random_settings();
      test_output_backpressure();
      test_long_waveform();
      settle();
      $display("covered %0d waveforms (%0d samples) under %0d register settings, %0d results",
               n_waves, n_samples, n_settings, n_results);
      $display("status ok %0d, long integral zero %0d, too short %0d; psd saturated %0d times",
               status_seen[psd_pkg::STATUS_OK], status_seen[psd_pkg::STATUS_ZERO],
               status_seen[psd_pkg::STATUS_SHORT], n_psd_sat);
      if (mismatches == 0 && expected_pulses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, expected_pulses.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
